/* hw/rtl/fdfg_pkg.sv */
// Package for the frequency domain filter gain unit: formats, constants, codes.
// Depends on nothing; used by fdfg_power and the top level.
package fdfg_pkg;

    localparam int IDX_W   = 10;
    localparam int D2_W    = 21;
    localparam int COEF_W  = 32;
    localparam int CUT_W   = 26;
    localparam int ORDER_W = 5;
    localparam int Q16_W   = 32;
    localparam int GAIN_W  = 17;
    localparam int ADDR_W  = 4;

    // Largest order the register can hold; one multiply stage per step.
    localparam int ORDER_MAX = (1 << ORDER_W) - 1;

    localparam logic [Q16_W-1:0]   ONE_Q16      = 32'h0001_0000;
    localparam logic [15:0]        SQRT2_M1_Q16 = 16'd27147;
    localparam logic [CUT_W-1:0]   CUTOFF_RST   = 26'd1600;
    localparam logic [ORDER_W-1:0] ORDER_RST    = 5'd1;

    typedef enum logic [1:0] {
        MODE_IDEAL_LOW = 2'd0,
        MODE_IDEAL_HIGH = 2'd1,
        MODE_BW_LOW = 2'd2,
        MODE_BW_HIGH = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        REG_MODE = 2'd0,
        REG_CUTOFF = 2'd1,
        REG_ORDER = 2'd2,
        REG_NONE = 2'd3
    } t_reg_idx;

    // Per-word sideband that rides along the arithmetic stages.
    typedef struct packed {
        logic              neg;
        logic [COEF_W-1:0] mag;
        logic              ideal;
        logic              pass;
        logic              zero;
        logic              sat;
    } t_side;

endpackage

/* hw/rtl/frequency_domain_filter_gain_unit.sv */
// Top level of the frequency domain filter gain unit: APB registers and the
// full pipeline. Depends on fdfg_pkg, fdfg_div and fdfg_power.
//
//   channel   valid     stall     payload
//   input     i_valid   o_stall   i_row_index, i_col_index, i_coefficient_in
//   output    o_valid   i_stall   o_coefficient_out
//   config    APB (psel, penable, pwrite, paddr, pwdata, prdata, pready)
//
// One word enters per clock unless the output stalls. The stages: one for
// the squared distance, 32 for the ratio divider, 31 for the power chain,
// one for the denominator, 17 for the gain divider, one for the product and
// one for the output register; the ratio divider and power chain set the depth.
// Reset is synchronous and clears the valid bits and the configuration registers.
// A stall on the output freezes every stage at once, so nothing is lost or
// repeated; o_stall is high only while a finished word waits at the output.
module frequency_domain_filter_gain_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [fdfg_pkg::IDX_W-1:0]     i_row_index,
    input  logic [fdfg_pkg::IDX_W-1:0]     i_col_index,
    input  logic signed [fdfg_pkg::COEF_W-1:0] i_coefficient_in,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [fdfg_pkg::COEF_W-1:0] o_coefficient_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fdfg_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import fdfg_pkg::*;

    localparam int SIDE_W = $bits(t_side);

    // ---------------- configuration registers ----------------
    t_mode              r_mode;
    logic [CUT_W-1:0]   r_cutoff;
    logic [ORDER_W-1:0] r_order;
    t_reg_idx           w_reg;

    assign pready = 1'b1;
    assign w_reg  = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDEAL_LOW;
            r_cutoff <= CUTOFF_RST;
            r_order  <= ORDER_RST;
        end else if (psel && penable && pwrite) begin
            case (w_reg)
                REG_MODE:   r_mode   <= t_mode'(pwdata[1:0]);
                REG_CUTOFF: r_cutoff <= pwdata[CUT_W-1:0];
                REG_ORDER:  r_order  <= pwdata[ORDER_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            REG_MODE:   prdata = {30'd0, r_mode};
            REG_CUTOFF: prdata = {6'd0, r_cutoff};
            REG_ORDER:  prdata = {27'd0, r_order};
            default:    prdata = '0;
        endcase
    end

    // ---------------- pipeline advance ----------------
    // Hold every stage while the output word is stalled.
    logic r_out_valid;
    logic w_adv;

    assign w_adv   = !(r_out_valid && i_stall);
    assign o_stall = !w_adv;
    assign o_valid = r_out_valid;

    // ---------------- stage 0: squared distance, magnitude ----------------
    logic              r0_valid;
    logic [D2_W-1:0]   r0_d2;
    logic              r0_neg;
    logic [COEF_W-1:0] r0_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (w_adv) begin
            r0_valid <= i_valid;
        end
    end

    // Negating the most negative value yields its own magnitude bits.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r0_d2  <= D2_W'({{IDX_W{1'b0}}, i_row_index} * {{IDX_W{1'b0}}, i_row_index})
                    + D2_W'({{IDX_W{1'b0}}, i_col_index} * {{IDX_W{1'b0}}, i_col_index});
            r0_neg <= i_coefficient_in[COEF_W-1];
            r0_mag <= i_coefficient_in[COEF_W-1] ? COEF_W'(-i_coefficient_in)
                                                 : COEF_W'(i_coefficient_in);
        end
    end

    // ---------------- ratio setup ----------------
    // Low pass divides d2<<20 by the cutoff, high pass cutoff<<12 by d2.
    // The quotient saturates exactly when the part above bit 31 of the
    // numerator reaches the divisor; a zero divisor lands there too.
    logic [CUT_W-2:0]  w_thr;
    logic              w_high;
    logic [CUT_W-1:0]  w_rd_rem;
    logic [Q16_W-1:0]  w_rd_num;
    logic [CUT_W-1:0]  w_rd_den;
    t_side             w_s1;

    assign w_thr  = (CUT_W-1)'(r_cutoff >> 4);
    assign w_high = r_mode[0];

    always_comb begin
        if (w_high) begin
            w_rd_rem = {20'd0, r_cutoff[25:20]};
            w_rd_num = {r_cutoff[19:0], 12'd0};
            w_rd_den = {5'd0, r0_d2};
        end else begin
            w_rd_rem = {17'd0, r0_d2[20:12]};
            w_rd_num = {r0_d2[11:0], 20'd0};
            w_rd_den = r_cutoff;
        end
        w_s1.neg   = r0_neg;
        w_s1.mag   = r0_mag;
        w_s1.ideal = !r_mode[1];
        w_s1.pass  = w_high ? ({4'd0, r0_d2} >= w_thr) : ({4'd0, r0_d2} <= w_thr);
        w_s1.zero  = w_high && (r0_d2 == '0);
        w_s1.sat   = (w_rd_rem >= w_rd_den);
    end

    logic              w_rq_valid;
    logic [Q16_W-1:0]  w_rq_quo;
    logic [SIDE_W-1:0] w_rq_side;
    t_side             w_s2;

    fdfg_div #(
        .Q_BITS (Q16_W),
        .D_BITS (CUT_W),
        .SIDE_W (SIDE_W)
    ) u_ratio_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r0_valid),
        .i_rem   (w_rd_rem),
        .i_num   (w_rd_num),
        .i_den   (w_rd_den),
        .i_side  (w_s1),
        .o_valid (w_rq_valid),
        .o_quo   (w_rq_quo),
        .o_side  (w_rq_side)
    );

    assign w_s2 = t_side'(w_rq_side);

    // ---------------- power chain ----------------
    logic             w_pw_valid;
    logic [Q16_W-1:0] w_pw_p;
    t_side            w_s3;

    fdfg_power u_power (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_rq_valid),
        .i_r     (w_s2.sat ? '1 : w_rq_quo),
        .i_order (r_order),
        .i_side  (w_s2),
        .o_valid (w_pw_valid),
        .o_p     (w_pw_p),
        .o_side  (w_s3)
    );

    // ---------------- denominator: 1 + K * p ----------------
    logic             r_d_valid;
    logic [Q16_W-1:0] r_d_den;
    t_side            r_d_side;
    logic [47:0]      w_kp;

    assign w_kp = SQRT2_M1_Q16 * w_pw_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (w_adv) begin
            r_d_valid <= w_pw_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d_den  <= ONE_Q16 + w_kp[47:16];
            r_d_side <= w_s3;
        end
    end

    // ---------------- gain = 2^32 / den ----------------
    // The numerator above the 17 quotient bits is 2^15; below them zero.
    logic              w_g_valid;
    logic [GAIN_W-1:0] w_g_quo;
    logic [SIDE_W-1:0] w_g_side;
    t_side             w_s4;

    fdfg_div #(
        .Q_BITS (GAIN_W),
        .D_BITS (Q16_W),
        .SIDE_W (SIDE_W)
    ) u_gain_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_d_valid),
        .i_rem   (Q16_W'(ONE_Q16 >> 1)),
        .i_num   ('0),
        .i_den   (r_d_den),
        .i_side  (r_d_side),
        .o_valid (w_g_valid),
        .o_quo   (w_g_quo),
        .o_side  (w_g_side)
    );

    assign w_s4 = t_side'(w_g_side);

    // ---------------- product stage ----------------
    logic                     w_gain;
    logic [GAIN_W-1:0]        w_gain_sel;
    logic                     r_m_valid;
    logic                     r_m_neg;
    logic [COEF_W+GAIN_W-1:0] r_m_prod;

    assign w_gain = 1'b1;
    always_comb begin
        if (w_s4.ideal) begin
            w_gain_sel = w_s4.pass ? GAIN_W'(ONE_Q16) : '0;
        end else begin
            w_gain_sel = (w_s4.zero && w_gain) ? '0 : w_g_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_adv) begin
            r_m_valid <= w_g_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m_neg  <= w_s4.neg;
            r_m_prod <= w_s4.mag * w_gain_sel;
        end
    end

    // ---------------- output register ----------------
    // Truncate the magnitude, then restore the sign: rounds toward zero.
    logic [COEF_W-1:0] w_m;
    logic [COEF_W-1:0] r_out;

    assign w_m = r_m_prod[COEF_W+15:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= r_m_neg ? (~w_m + 1'b1) : w_m;
        end
    end

    assign o_coefficient_out = r_out;

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled without a waiting output word");

    a_gain_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_g_valid |-> (w_g_quo <= GAIN_W'(ONE_Q16)))
        else $error("gain divider produced a gain above one");

    a_zero_gain_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_m_valid && (r_m_prod == '0)) |=> (o_coefficient_out == '0))
        else $error("zero product did not give a zero word");
`endif

endmodule

/* hw/rtl/fdfg_div.sv */
// Pipelined restoring divider, one quotient bit per register stage.
// Self-contained; instantiated by the top level for the ratio and the gain.
module fdfg_div #(
    parameter int Q_BITS = 32,
    parameter int D_BITS = 26,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [D_BITS-1:0] i_rem,
    input  logic [Q_BITS-1:0] i_num,
    input  logic [D_BITS-1:0] i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [Q_BITS-1:0] o_quo,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_v    [Q_BITS];
    logic [D_BITS-1:0] r_rem  [Q_BITS];
    logic [Q_BITS-1:0] r_q    [Q_BITS];
    logic [D_BITS-1:0] r_den  [Q_BITS];
    logic [SIDE_W-1:0] r_side [Q_BITS];

    for (genvar k = 0; k < Q_BITS; k++) begin : g_step
        logic              w_v;
        logic [D_BITS-1:0] w_rem;
        logic [Q_BITS-1:0] w_q;
        logic [D_BITS-1:0] w_den;
        logic [SIDE_W-1:0] w_side;
        logic [D_BITS:0]   w_sh;
        logic [D_BITS:0]   w_diff;
        logic              w_ge;

        if (k == 0) begin : g_first
            assign w_v    = i_valid;
            assign w_rem  = i_rem;
            assign w_q    = i_num;
            assign w_den  = i_den;
            assign w_side = i_side;
        end else begin : g_next
            assign w_v    = r_v[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_q    = r_q[k-1];
            assign w_den  = r_den[k-1];
            assign w_side = r_side[k-1];
        end

        // Shift in the next numerator bit, subtract when it fits.
        assign w_sh   = {w_rem, w_q[Q_BITS-1]};
        assign w_diff = w_sh - {1'b0, w_den};
        assign w_ge   = (w_sh >= {1'b0, w_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? w_diff[D_BITS-1:0] : w_sh[D_BITS-1:0];
                r_q[k]    <= {w_q[Q_BITS-2:0], w_ge};
                r_den[k]  <= w_den;
                r_side[k] <= w_side;
            end
        end
    end

    assign o_valid = r_v[Q_BITS-1];
    assign o_quo   = r_q[Q_BITS-1];
    assign o_side  = r_side[Q_BITS-1];

endmodule

/* hw/rtl/fdfg_power.sv */
// Power chain: raises a Q16.16 ratio to the configured order, one
// truncating, saturating multiply per stage. Depends on fdfg_pkg.
module fdfg_power (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [fdfg_pkg::Q16_W-1:0]      i_r,
    input  logic [fdfg_pkg::ORDER_W-1:0]    i_order,
    input  fdfg_pkg::t_side                 i_side,
    output logic                            o_valid,
    output logic [fdfg_pkg::Q16_W-1:0]      o_p,
    output fdfg_pkg::t_side                 o_side
);
    import fdfg_pkg::*;

    logic             r_v    [ORDER_MAX];
    logic [Q16_W-1:0] r_p    [ORDER_MAX];
    logic [Q16_W-1:0] r_r    [ORDER_MAX];
    t_side            r_side [ORDER_MAX];

    for (genvar k = 0; k < ORDER_MAX; k++) begin : g_mul
        localparam logic [ORDER_W-1:0] STEP = ORDER_W'(k);
        logic               w_v;
        logic [Q16_W-1:0]   w_p;
        logic [Q16_W-1:0]   w_r;
        t_side              w_side;
        logic [2*Q16_W-1:0] w_prod;
        logic [Q16_W-1:0]   w_next;

        if (k == 0) begin : g_first
            assign w_v    = i_valid;
            assign w_p    = ONE_Q16;
            assign w_r    = i_r;
            assign w_side = i_side;
        end else begin : g_next
            assign w_v    = r_v[k-1];
            assign w_p    = r_p[k-1];
            assign w_r    = r_r[k-1];
            assign w_side = r_side[k-1];
        end

        assign w_prod = w_p * w_r;
        // Saturate when the shifted product overflows 32 bits.
        assign w_next = (|w_prod[2*Q16_W-1:Q16_W+16]) ? '1 : w_prod[Q16_W+15:16];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p[k]    <= (STEP < i_order) ? w_next : w_p;
                r_r[k]    <= w_r;
                r_side[k] <= w_side;
            end
        end
    end

    assign o_valid = r_v[ORDER_MAX-1];
    assign o_p     = r_p[ORDER_MAX-1];
    assign o_side  = r_side[ORDER_MAX-1];

endmodule
